[design/rfc_pkg.sv]
// shared types, constants and register codes for the raster fill and copy engine
package rfc_pkg;

	localparam int MAX_WIDTH = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int PIXEL_BITS = 32;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int QDEPTH = 2;
	localparam int PADDR_W = 5;

	typedef enum logic [1:0] {
		ACT_SET  = 2'd0,
		ACT_GET  = 2'd1,
		ACT_FILL = 2'd2,
		ACT_COPY = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_ENABLED   = 3'd0,
		REG_FWIDTH    = 3'd1,
		REG_FHEIGHT   = 3'd2,
		REG_STRIDE    = 3'd3,
		REG_CLIP_L    = 3'd4,
		REG_CLIP_T    = 3'd5,
		REG_CLIP_SX   = 3'd6,
		REG_CLIP_SY   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] dest_x;
		logic signed [15:0] dest_y;
		logic signed [15:0] src_x;
		logic signed [15:0] src_y;
		logic signed [15:0] rect_width;
		logic signed [15:0] rect_height;
		logic [31:0]        color;
	} cmd_t;

	typedef struct packed {
		logic [31:0] pixel_value;
		logic [16:0] written_count;
	} res_t;

	// classified command: all bounds resolved, coordinates in frame
	typedef struct packed {
		action_t     op;
		logic        empty;
		logic [XW:0] x0;
		logic [XW:0] x1;
		logic [YW:0] y0;
		logic [YW:0] y1;
		logic [XW:0] sx0;
		logic [YW:0] sy0;
		logic        rev_x;
		logic        rev_y;
		logic [31:0] color;
	} job_t;

	typedef struct packed {
		logic        enabled;
		logic [8:0]  width;
		logic [8:0]  height;
		logic [8:0]  stride;
		logic [8:0]  clip_left;
		logic [8:0]  clip_top;
		logic [8:0]  clip_span_x;
		logic [8:0]  clip_span_y;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_WR,
		ST_DONE
	} bst_t;

endpackage

[design/raster_fill_copy_engine.sv]
// top level of the raster fill and copy engine: register port, front, queue, back
//
//  channel  direction  handshake        payload
//  cmd      in         cmd_valid/stall  rfc_pkg::cmd_t
//  res      out        res_valid/stall  rfc_pkg::res_t
//  apb      in         psel/penable     8 registers at 4*i
//
// after reset the back end clears the 65536-word frame memory, one word a
// cycle; commands wait in the front end and queue until the clear is done.
// an empty item goes straight to its result; set and fill write each pixel,
// get reads one, copy reads and then writes each pixel; the single memory port
// does one read or one write a cycle
// front stages and the two-entry queue hold up to four items; stall on res holds the back end
module raster_fill_copy_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  rfc_pkg::cmd_t                 cmd,
	output logic                          res_valid,
	input  logic                          res_stall,
	output rfc_pkg::res_t                 res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rfc_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	rfc_pkg::cfg_t cfg_q;
	rfc_pkg::job_t fj, qj;
	logic fv, fs, qv, qs;
	rfc_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign idx = rfc_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled <= 1'b0;
			cfg_q.width <= 9'd256;
			cfg_q.height <= 9'd256;
			cfg_q.stride <= 9'd256;
			cfg_q.clip_left <= 9'd0;
			cfg_q.clip_top <= 9'd0;
			cfg_q.clip_span_x <= 9'd256;
			cfg_q.clip_span_y <= 9'd256;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				rfc_pkg::REG_ENABLED: cfg_q.enabled <= pwdata[0];
				rfc_pkg::REG_FWIDTH:  cfg_q.width <= pwdata[8:0];
				rfc_pkg::REG_FHEIGHT: cfg_q.height <= pwdata[8:0];
				rfc_pkg::REG_STRIDE:  cfg_q.stride <= pwdata[8:0];
				rfc_pkg::REG_CLIP_L:  cfg_q.clip_left <= pwdata[8:0];
				rfc_pkg::REG_CLIP_T:  cfg_q.clip_top <= pwdata[8:0];
				rfc_pkg::REG_CLIP_SX: cfg_q.clip_span_x <= pwdata[8:0];
				rfc_pkg::REG_CLIP_SY: cfg_q.clip_span_y <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			rfc_pkg::REG_ENABLED: prdata = {31'd0, cfg_q.enabled};
			rfc_pkg::REG_FWIDTH:  prdata = {23'd0, cfg_q.width};
			rfc_pkg::REG_FHEIGHT: prdata = {23'd0, cfg_q.height};
			rfc_pkg::REG_STRIDE:  prdata = {23'd0, cfg_q.stride};
			rfc_pkg::REG_CLIP_L:  prdata = {23'd0, cfg_q.clip_left};
			rfc_pkg::REG_CLIP_T:  prdata = {23'd0, cfg_q.clip_top};
			rfc_pkg::REG_CLIP_SX: prdata = {23'd0, cfg_q.clip_span_x};
			rfc_pkg::REG_CLIP_SY: prdata = {23'd0, cfg_q.clip_span_y};
			default: prdata = '0;
		endcase
	end

	logic [8:0] stride_e;
	assign stride_e = (cfg_q.stride > 9'(rfc_pkg::MAX_WIDTH)) ?
		9'(rfc_pkg::MAX_WIDTH) : cfg_q.stride;

	rfc_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.job_valid(fv), .job_stall(fs), .job(fj)
	);

	rfc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(fv), .in_stall(fs), .in_job(fj),
		.out_valid(qv), .out_stall(qs), .out_job(qj)
	);

	rfc_back u_back (
		.clk(clk), .arst_n(arst_n), .stride(stride_e),
		.job_valid(qv), .job_stall(qs), .job(qj),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);
endmodule

[design/rfc_front.sv]
// front end: accepts commands, clips against the frame and classifies them
module rfc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  rfc_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  rfc_pkg::cmd_t cmd,
	output logic          job_valid,
	input  logic          job_stall,
	output rfc_pkg::job_t job
);
	localparam int XW = rfc_pkg::XW;
	localparam int YW = rfc_pkg::YW;

	// stage 1 registers: effective frame, clip window, enable and raw command
	logic                 v_s1;
	rfc_pkg::cmd_t        c_s1;
	logic signed [17:0]   w_s1, h_s1;
	logic                 en_s1;
	logic [8:0]           cl_s1, ct_s1, csx_s1, csy_s1;

	logic                 v_q;
	rfc_pkg::job_t        job_q;
	logic                 adv1;

	logic [8:0] stride_e, w_e, h_e;
	always_comb begin
		stride_e = (cfg.stride > 9'(rfc_pkg::MAX_WIDTH)) ? 9'(rfc_pkg::MAX_WIDTH) : cfg.stride;
		w_e = (cfg.width < stride_e) ? cfg.width : stride_e;
		h_e = (cfg.height > 9'(rfc_pkg::MAX_HEIGHT)) ? 9'(rfc_pkg::MAX_HEIGHT) : cfg.height;
	end

	assign adv1 = !v_q || !job_stall;
	assign cmd_stall = v_s1 && !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			v_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			c_s1   <= cmd;
			w_s1   <= 18'(w_e);
			h_s1   <= 18'(h_e);
			en_s1  <= cfg.enabled;
			cl_s1  <= cfg.clip_left;
			ct_s1  <= cfg.clip_top;
			csx_s1 <= cfg.clip_span_x;
			csy_s1 <= cfg.clip_span_y;
		end
	end

	// stage 2: bounds
	logic signed [17:0] dx, dy, sx, sy, rw, rh;
	logic signed [17:0] ox0, ox1, oy0, oy1, a, b;
	logic signed [17:0] fx0, fx1, fy0, fy1;
	logic in_frame, in_clip;
	rfc_pkg::job_t j;

	always_comb begin
		dx = 18'(c_s1.dest_x);
		dy = 18'(c_s1.dest_y);
		sx = 18'(c_s1.src_x);
		sy = 18'(c_s1.src_y);
		rw = 18'(c_s1.rect_width);
		rh = 18'(c_s1.rect_height);
		in_frame = dx >= 0 && dx < w_s1 && dy >= 0 && dy < h_s1;
		in_clip = dx >= $signed({9'd0, cl_s1}) &&
			dx < $signed(18'({1'b0, cl_s1} + {1'b0, csx_s1})) &&
			dy >= $signed({9'd0, ct_s1}) &&
			dy < $signed(18'({1'b0, ct_s1} + {1'b0, csy_s1}));
		// fill bounds
		fx0 = (dx > 0) ? dx : 18'sd0;
		fx1 = (dx + rw < w_s1) ? dx + rw : w_s1;
		fy0 = (dy > 0) ? dy : 18'sd0;
		fy1 = (dy + rh < h_s1) ? dy + rh : h_s1;
		// copy offsets
		a = (-sx > -dx) ? -sx : -dx;
		ox0 = (a > 0) ? a : 18'sd0;
		b = (w_s1 - sx < w_s1 - dx) ? w_s1 - sx : w_s1 - dx;
		ox1 = (rw < b) ? rw : b;
		a = (-sy > -dy) ? -sy : -dy;
		oy0 = (a > 0) ? a : 18'sd0;
		b = (h_s1 - sy < h_s1 - dy) ? h_s1 - sy : h_s1 - dy;
		oy1 = (rh < b) ? rh : b;

		j = '0;
		j.op = rfc_pkg::action_t'(c_s1.action);
		j.color = c_s1.color;
		unique case (rfc_pkg::action_t'(c_s1.action))
			rfc_pkg::ACT_SET: begin
				j.empty = !(in_frame && in_clip);
				j.x0 = (XW+1)'(dx);
				j.y0 = (YW+1)'(dy);
				j.x1 = (XW+1)'(dx + 1);
				j.y1 = (YW+1)'(dy + 1);
			end
			rfc_pkg::ACT_GET: begin
				j.empty = !in_frame;
				j.x0 = (XW+1)'(dx);
				j.y0 = (YW+1)'(dy);
				j.x1 = (XW+1)'(dx + 1);
				j.y1 = (YW+1)'(dy + 1);
			end
			rfc_pkg::ACT_FILL: begin
				j.empty = !(fx1 > fx0 && fy1 > fy0);
				j.x0 = (XW+1)'(fx0);
				j.x1 = (XW+1)'(fx1);
				j.y0 = (YW+1)'(fy0);
				j.y1 = (YW+1)'(fy1);
			end
			rfc_pkg::ACT_COPY: begin
				j.empty = !(ox1 > ox0 && oy1 > oy0);
				j.x0 = (XW+1)'(dx + ox0);
				j.x1 = (XW+1)'(dx + ox1);
				j.y0 = (YW+1)'(dy + oy0);
				j.y1 = (YW+1)'(dy + oy1);
				j.sx0 = (XW+1)'(sx + ox0);
				j.sy0 = (YW+1)'(sy + oy0);
				j.rev_x = dx > sx;
				j.rev_y = dy > sy;
			end
			default: j.empty = 1'b1;
		endcase
		if (!en_s1) begin
			j.empty = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv1) begin
			v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && v_s1) begin
			job_q <= j;
		end
	end

	assign job_valid = v_q;
	assign job = job_q;
endmodule

[design/rfc_queue.sv]
// small command queue between front and back ends
module rfc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rfc_pkg::job_t in_job,
	output logic          out_valid,
	input  logic          out_stall,
	output rfc_pkg::job_t out_job
);
	localparam int PW = $clog2(rfc_pkg::QDEPTH);
	rfc_pkg::job_t    mem_q [rfc_pkg::QDEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;
	logic             push, pop;

	assign in_stall = cnt_q == (PW+1)'(rfc_pkg::QDEPTH);
	assign out_valid = cnt_q != '0;
	assign push = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;
	assign out_job = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_job;
		end
	end
endmodule

[design/rfc_back.sv]
// back end: walks pixels of each command over the frame memory
module rfc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [8:0]    stride,
	input  logic          job_valid,
	output logic          job_stall,
	input  rfc_pkg::job_t job,
	output logic          res_valid,
	input  logic          res_stall,
	output rfc_pkg::res_t res
);
	localparam int XW = rfc_pkg::XW;
	localparam int YW = rfc_pkg::YW;
	localparam int AW = rfc_pkg::AW;

	logic [31:0] mem [rfc_pkg::DEPTH];

	rfc_pkg::bst_t st_q, st_d;
	rfc_pkg::job_t j_q;
	logic [AW:0]   clr_q;
	logic [XW:0]   ox_q, ow_q;
	logic [YW:0]   oy_q, oh_q;
	logic [16:0]   cnt_q;
	logic [31:0]   rd_q, pix_q;
	logic          rv_q;
	rfc_pkg::res_t res_q;

	logic [XW:0] dxp, sxp;
	logic [YW:0] dyp, syp;
	logic [AW-1:0] daddr, saddr;
	logic last_x, last_y;
	logic take;

	// direction of walk keeps the copy overlap-safe
	always_comb begin
		dxp = j_q.rev_x ? j_q.x0 + (ow_q - 1'b1 - ox_q) : j_q.x0 + ox_q;
		sxp = j_q.rev_x ? j_q.sx0 + (ow_q - 1'b1 - ox_q) : j_q.sx0 + ox_q;
		dyp = j_q.rev_y ? j_q.y0 + (oh_q - 1'b1 - oy_q) : j_q.y0 + oy_q;
		syp = j_q.rev_y ? j_q.sy0 + (oh_q - 1'b1 - oy_q) : j_q.sy0 + oy_q;
		daddr = AW'(dyp[YW-1:0] * stride + {1'b0, dxp[XW-1:0]});
		saddr = AW'(syp[YW-1:0] * stride + {1'b0, sxp[XW-1:0]});
		last_x = ox_q == ow_q - 1'b1;
		last_y = oy_q == oh_q - 1'b1;
	end

	assign take = st_q == rfc_pkg::ST_IDLE && job_valid;
	assign job_stall = !take;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			rfc_pkg::ST_CLEAR:
				if (clr_q == (AW+1)'(rfc_pkg::DEPTH - 1)) st_d = rfc_pkg::ST_IDLE;
			rfc_pkg::ST_IDLE:
				if (job_valid) begin
					if (job.empty) st_d = rfc_pkg::ST_DONE;
					else if (job.op == rfc_pkg::ACT_SET || job.op == rfc_pkg::ACT_FILL)
						st_d = rfc_pkg::ST_WR;
					else st_d = rfc_pkg::ST_RD;
				end
			rfc_pkg::ST_RD:
				st_d = (j_q.op == rfc_pkg::ACT_GET) ? rfc_pkg::ST_DONE : rfc_pkg::ST_WR;
			rfc_pkg::ST_WR:
				if (last_x && last_y) st_d = rfc_pkg::ST_DONE;
				else if (j_q.op == rfc_pkg::ACT_COPY) st_d = rfc_pkg::ST_RD;
			rfc_pkg::ST_DONE:
				if (!rv_q || !res_stall) st_d = rfc_pkg::ST_IDLE;
			default: st_d = rfc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rfc_pkg::ST_CLEAR;
			clr_q <= '0;
			rv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == rfc_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (st_q == rfc_pkg::ST_DONE && (!rv_q || !res_stall)) rv_q <= 1'b1;
			else if (!res_stall) rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == rfc_pkg::ST_CLEAR) begin
			mem[clr_q[AW-1:0]] <= '0;
		end else if (st_q == rfc_pkg::ST_WR) begin
			mem[daddr] <= (j_q.op == rfc_pkg::ACT_COPY) ? rd_q : j_q.color;
		end
		if (st_q == rfc_pkg::ST_RD) begin
			rd_q <= mem[(j_q.op == rfc_pkg::ACT_GET) ? daddr : saddr];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			j_q <= job;
			ox_q <= '0;
			oy_q <= '0;
			ow_q <= job.x1 - job.x0;
			oh_q <= job.y1 - job.y0;
			cnt_q <= '0;
			pix_q <= '0;
		end else if (st_q == rfc_pkg::ST_WR) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_x) begin
				ox_q <= '0;
				oy_q <= oy_q + 1'b1;
			end else begin
				ox_q <= ox_q + 1'b1;
			end
		end else if (st_q == rfc_pkg::ST_RD && j_q.op == rfc_pkg::ACT_GET) begin
			pix_q <= mem[daddr];
		end
		if (st_q == rfc_pkg::ST_DONE && (!rv_q || !res_stall)) begin
			res_q.pixel_value <= pix_q;
			res_q.written_count <= cnt_q;
		end
	end

	assign res_valid = rv_q;
	assign res = res_q;
endmodule

[bench/raster_fill_copy_engine_tb.sv]
// testbench for the raster fill and copy engine: directed and random commands against a predictor
module raster_fill_copy_engine_tb;

	logic                         clk;
	logic                         arst_n;
	logic                         cmd_valid;
	logic                         cmd_stall;
	rfc_pkg::cmd_t                cmd;
	logic                         res_valid;
	logic                         res_stall;
	rfc_pkg::res_t                res;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [rfc_pkg::PADDR_W-1:0]  paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	raster_fill_copy_engine uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	bit [31:0]     frame_copy [rfc_pkg::DEPTH];
	rfc_pkg::cfg_t cfg_copy;
	rfc_pkg::res_t pending_res [$];
	int            fails = 0;
	bit            quiet = 0;
	int            stall_left = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic int imin(int a, int b);
		return a < b ? a : b;
	endfunction

	function automatic int imax(int a, int b);
		return a > b ? a : b;
	endfunction

	function automatic int stride_eff();
		return imin(int'(cfg_copy.stride), rfc_pkg::MAX_WIDTH);
	endfunction

	function automatic int width_eff();
		return imin(int'(cfg_copy.width), stride_eff());
	endfunction

	function automatic int height_eff();
		return imin(int'(cfg_copy.height), rfc_pkg::MAX_HEIGHT);
	endfunction

	function automatic rfc_pkg::res_t raster_predict(rfc_pkg::cmd_t c);
		int dx, dy, sx, sy, rw, rh, w, h, st, cnt, n, rows;
		int ox0, ox1, oy0, oy1;
		bit [31:0] pix;
		bit [31:0] snap [];
		rfc_pkg::res_t r;
		dx = $signed(c.dest_x); dy = $signed(c.dest_y);
		sx = $signed(c.src_x); sy = $signed(c.src_y);
		rw = $signed(c.rect_width); rh = $signed(c.rect_height);
		st = stride_eff(); w = width_eff(); h = height_eff();
		pix = 0; cnt = 0;
		if (cfg_copy.enabled) begin
			case (rfc_pkg::action_t'(c.action))
				rfc_pkg::ACT_SET: begin
					if (dx >= 0 && dx < w && dy >= 0 && dy < h &&
					    dx >= int'(cfg_copy.clip_left) &&
					    dx < int'(cfg_copy.clip_left) + int'(cfg_copy.clip_span_x) &&
					    dy >= int'(cfg_copy.clip_top) &&
					    dy < int'(cfg_copy.clip_top) + int'(cfg_copy.clip_span_y)) begin
						frame_copy[dy * st + dx] = c.color;
						cnt = 1;
					end
				end
				rfc_pkg::ACT_GET: begin
					if (dx >= 0 && dx < w && dy >= 0 && dy < h)
						pix = frame_copy[dy * st + dx];
				end
				rfc_pkg::ACT_FILL: begin
					for (int y = imax(dy, 0); y < imin(dy + rh, h); y++)
						for (int x = imax(dx, 0); x < imin(dx + rw, w); x++) begin
							frame_copy[y * st + x] = c.color;
							cnt++;
						end
				end
				rfc_pkg::ACT_COPY: begin
					ox0 = imax(0, imax(-sx, -dx));
					ox1 = imin(rw, imin(w - sx, w - dx));
					oy0 = imax(0, imax(-sy, -dy));
					oy1 = imin(rh, imin(h - sy, h - dy));
					if (ox1 > ox0 && oy1 > oy0) begin
						n = ox1 - ox0;
						rows = oy1 - oy0;
						// read the whole source first, so overlap behaves as a snapshot
						snap = new[n * rows];
						for (int j = 0; j < rows; j++)
							for (int i = 0; i < n; i++)
								snap[j * n + i] = frame_copy[(sy + oy0 + j) * st + sx + ox0 + i];
						for (int j = 0; j < rows; j++)
							for (int i = 0; i < n; i++)
								frame_copy[(dy + oy0 + j) * st + dx + ox0 + i] = snap[j * n + i];
						cnt = n * rows;
					end
				end
				default: ;
			endcase
		end
		r.pixel_value = pix;
		r.written_count = cnt[16:0];
		return r;
	endfunction

	// called at a rising edge; returns at or after the edge that accepted the item
	task automatic send_cmd(rfc_pkg::cmd_t c);
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		pending_res.push_back(raster_predict(c));
		if (!quiet && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	function automatic rfc_pkg::cmd_t mk_cmd(rfc_pkg::action_t a, int dx, int dy, int sx,
			int sy, int rw, int rh, bit [31:0] col);
		rfc_pkg::cmd_t c;
		c.action = a;
		c.dest_x = dx[15:0]; c.dest_y = dy[15:0];
		c.src_x = sx[15:0]; c.src_y = sy[15:0];
		c.rect_width = rw[15:0]; c.rect_height = rh[15:0];
		c.color = col;
		return c;
	endfunction

	function automatic int near_coord(int lim);
		return int'($urandom_range(0, lim + 16)) - 8;
	endfunction

	function automatic rfc_pkg::cmd_t rand_cmd();
		rfc_pkg::cmd_t c;
		int lw, lh;
		lw = width_eff(); lh = height_eff();
		if ($urandom_range(0, 15) == 0) begin
			c = rfc_pkg::cmd_t'({2'($urandom), $urandom, $urandom, $urandom, $urandom});
		end else begin
			c = mk_cmd(rfc_pkg::action_t'($urandom_range(0, 3)), near_coord(lw),
				near_coord(lh), near_coord(lw), near_coord(lh),
				int'($urandom_range(0, 24)) - 4, int'($urandom_range(0, 24)) - 4, $urandom);
		end
		return c;
	endfunction

	task automatic drain();
		cmd_valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(rfc_pkg::reg_idx_t r, int v);
		paddr <= rfc_pkg::PADDR_W'(int'(r) * 4);
		pwdata <= v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			rfc_pkg::REG_ENABLED: cfg_copy.enabled = v[0];
			rfc_pkg::REG_FWIDTH:  cfg_copy.width = v[8:0];
			rfc_pkg::REG_FHEIGHT: cfg_copy.height = v[8:0];
			rfc_pkg::REG_STRIDE:  cfg_copy.stride = v[8:0];
			rfc_pkg::REG_CLIP_L:  cfg_copy.clip_left = v[8:0];
			rfc_pkg::REG_CLIP_T:  cfg_copy.clip_top = v[8:0];
			rfc_pkg::REG_CLIP_SX: cfg_copy.clip_span_x = v[8:0];
			rfc_pkg::REG_CLIP_SY: cfg_copy.clip_span_y = v[8:0];
			default: ;
		endcase
	endtask

	task automatic set_frame(int w, int h, int st);
		reg_write(rfc_pkg::REG_FWIDTH, w);
		reg_write(rfc_pkg::REG_FHEIGHT, h);
		reg_write(rfc_pkg::REG_STRIDE, st);
	endtask

	task automatic set_clip(int l, int t, int sx, int sy);
		reg_write(rfc_pkg::REG_CLIP_L, l);
		reg_write(rfc_pkg::REG_CLIP_T, t);
		reg_write(rfc_pkg::REG_CLIP_SX, sx);
		reg_write(rfc_pkg::REG_CLIP_SY, sy);
	endtask

	task automatic run_random(int n);
		repeat (n) send_cmd(rand_cmd());
		drain();
	endtask

	task automatic test_disabled();
		send_cmd(mk_cmd(rfc_pkg::ACT_SET, 3, 3, 0, 0, 0, 0, 32'hdead_beef));
		send_cmd(mk_cmd(rfc_pkg::ACT_FILL, 0, 0, 0, 0, 8, 8, 32'h1234_5678));
		send_cmd(mk_cmd(rfc_pkg::ACT_COPY, 4, 4, 0, 0, 4, 4, 0));
		send_cmd(mk_cmd(rfc_pkg::ACT_GET, 3, 3, 0, 0, 0, 0, 0));
		drain();
	endtask

	task automatic test_directed();
		reg_write(rfc_pkg::REG_ENABLED, 1);
		send_cmd(mk_cmd(rfc_pkg::ACT_SET, 0, 0, 0, 0, 0, 0, 32'hffff_ffff));
		send_cmd(mk_cmd(rfc_pkg::ACT_SET, 255, 255, 0, 0, 0, 0, 32'h8000_0001));
		send_cmd(mk_cmd(rfc_pkg::ACT_SET, 256, 0, 0, 0, 0, 0, 32'h5555_5555));
		send_cmd(mk_cmd(rfc_pkg::ACT_SET, -1, 5, 0, 0, 0, 0, 32'haaaa_aaaa));
		send_cmd(mk_cmd(rfc_pkg::ACT_GET, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(rfc_pkg::ACT_GET, 255, 255, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(rfc_pkg::ACT_GET, -32768, 32767, -32768, 32767, -32768, 32767, 0));
		send_cmd(mk_cmd(rfc_pkg::ACT_FILL, -2, -1, 0, 0, 6, 4, 32'h0f0f_0f0f));
		send_cmd(mk_cmd(rfc_pkg::ACT_FILL, 10, 10, 0, 0, 0, 5, 32'h1));
		send_cmd(mk_cmd(rfc_pkg::ACT_FILL, 10, 10, 0, 0, 5, -32768, 32'h1));
		send_cmd(mk_cmd(rfc_pkg::ACT_FILL, 0, 0, 0, 0, 32767, 32767, 32'hc0de_0001));
		send_cmd(mk_cmd(rfc_pkg::ACT_SET, 2, 0, 0, 0, 0, 0, 32'h2));
		send_cmd(mk_cmd(rfc_pkg::ACT_SET, 3, 0, 0, 0, 0, 0, 32'h3));
		// same-row rightward overlap, then leftward, down and up
		send_cmd(mk_cmd(rfc_pkg::ACT_COPY, 1, 0, 0, 0, 8, 1, 0));
		send_cmd(mk_cmd(rfc_pkg::ACT_COPY, 0, 0, 2, 0, 8, 2, 0));
		send_cmd(mk_cmd(rfc_pkg::ACT_COPY, 0, 2, 0, 0, 6, 5, 0));
		send_cmd(mk_cmd(rfc_pkg::ACT_COPY, 1, 0, 0, 3, 6, 5, 0));
		send_cmd(mk_cmd(rfc_pkg::ACT_COPY, 250, 250, -3, 252, 10, 10, 0));
		send_cmd(mk_cmd(rfc_pkg::ACT_COPY, 60, 60, 0, 0, 128, 128, 0));
		for (int i = 0; i < 5; i++)
			send_cmd(mk_cmd(rfc_pkg::ACT_GET, i, i % 3, 0, 0, 0, 0, 0));
		drain();
	endtask

	task automatic test_clip();
		set_clip(10, 20, 30, 5);
		run_random(90);
		set_clip(256, 256, 0, 0);
		run_random(20);
	endtask

	task automatic test_narrow_frame();
		set_clip(0, 0, 256, 256);
		set_frame(40, 30, 64);
		run_random(90);
	endtask

	task automatic test_short_stride();
		set_frame(256, 300, 17);
		set_clip(5, 0, 8, 256);
		run_random(90);
	endtask

	task automatic test_oversized();
		set_frame(511, 511, 511);
		set_clip(0, 0, 511, 511);
		run_random(90);
	endtask

	task automatic test_empty_frame();
		set_frame(20, 20, 0);
		run_random(15);
		set_frame(0, 0, 1);
		run_random(15);
		set_frame(1, 256, 1);
		run_random(25);
	endtask

	task automatic test_reenable();
		reg_write(rfc_pkg::REG_ENABLED, 0);
		set_frame(256, 256, 256);
		set_clip(0, 0, 256, 256);
		run_random(10);
		reg_write(rfc_pkg::REG_ENABLED, 1);
		quiet = 1;
		run_random(120);
	endtask

	// result side: random stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 4);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_res.size() == 0) begin
				$display("%0t: result expected none actual %h/%0d", $time,
					res.pixel_value, res.written_count);
				fails++;
			end else begin
				if (res.pixel_value !== pending_res[0].pixel_value) begin
					$display("%0t: pixel_value expected %h actual %h", $time,
						pending_res[0].pixel_value, res.pixel_value);
					fails++;
				end
				if (res.written_count !== pending_res[0].written_count) begin
					$display("%0t: written_count expected %0d actual %0d", $time,
						pending_res[0].written_count, res.written_count);
					fails++;
				end
				void'(pending_res.pop_front());
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		res_stall <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cfg_copy = '{enabled: 1'b0, width: 9'd256, height: 9'd256, stride: 9'd256,
			clip_left: 9'd0, clip_top: 9'd0, clip_span_x: 9'd256, clip_span_y: 9'd256};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled();
		test_directed();
		test_clip();
		test_narrow_frame();
		test_short_stride();
		test_oversized();
		test_empty_frame();
		test_reenable();
		repeat (20) @(posedge clk);
		if (fails == 0 && pending_res.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#300000000;
		$display("status: fail");
		$finish;
	end

endmodule
